@@ hdl/ascii_beacon_frame_parser_macros.svh @@
// Assertion macros shared by the beacon frame parser RTL.
`ifndef ASCII_BEACON_FRAME_PARSER_MACROS_SVH
`define ASCII_BEACON_FRAME_PARSER_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ABFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ABFP_ASSERT_IMPLY(label, cond, cons, msg) \
  `ABFP_ASSERT(label, (cond) |-> (cons), msg)

// Check that a condition implies a consequence in the next cycle.
`define ABFP_ASSERT_NEXT(label, cond, cons, msg) \
  `ABFP_ASSERT(label, (cond) |=> (cons), msg)

`endif

@@ hdl/abfp_pkg.sv @@
// Types, constants and helpers for the beacon frame parser.
package abfp_pkg;

  localparam int unsigned SeqWidthDefault = 32;
  localparam int unsigned SeqOutW         = 32;
  localparam int unsigned PosW            = 4;
  localparam int unsigned ByteW           = 8;

  localparam logic [PosW-1:0] PrefixLen = 4'd6;
  localparam logic [PosW-1:0] SenderPos = 4'd6;
  localparam logic [PosW-1:0] CommaPos  = 4'd7;
  localparam logic [PosW-1:0] DigitPos  = 4'd8;
  localparam logic [PosW-1:0] SatPos    = 4'd9;

  localparam logic [ByteW-1:0] CharZero  = 8'h30;
  localparam logic [ByteW-1:0] CharOne   = 8'h31;
  localparam logic [ByteW-1:0] CharNine  = 8'h39;
  localparam logic [ByteW-1:0] CharComma = 8'h2c;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StFormat   = 2'd1,
    StSender   = 2'd2,
    StSequence = 2'd3
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] frame_byte;
    logic             last_byte;
  } byte_t;

  typedef struct packed {
    status_e            status;
    logic               sender;
    logic [SeqOutW-1:0] sequence_number;
  } result_t;

  // Expected prefix byte at a given position.
  function automatic logic [ByteW-1:0] prefix_byte(input logic [2:0] idx);
    logic [ByteW-1:0] b;
    unique case (idx)
      3'd0:    b = 8'h53;
      3'd1:    b = 8'h49;
      3'd2:    b = 8'h4d;
      3'd3:    b = 8'h41;
      3'd4:    b = 8'h49;
      3'd5:    b = CharComma;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ hdl/abfp_input_reg.sv @@
// Input register stage holding one accepted frame byte.
module abfp_input_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  abfp_pkg::byte_t byte_i,
  input  logic          advance_i,
  output logic          valid_o,
  output abfp_pkg::byte_t byte_o
);

  logic            valid_q, valid_d;
  abfp_pkg::byte_t byte_q;
  logic            load;

  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

@@ hdl/abfp_parse_core.sv @@
// Frame state, per-byte checks, decimal accumulator and result formation.
module abfp_parse_core #(
  parameter int unsigned SequenceWidth = abfp_pkg::SeqWidthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  abfp_pkg::byte_t   byte_i,
  output logic              res_valid_o,
  output abfp_pkg::result_t res_o
);

  localparam int unsigned ExtW = SequenceWidth + 4;

  logic [abfp_pkg::PosW-1:0] pos_q, pos_d;
  logic                      prefix_q, prefix_d;
  logic                      snd_ok_q, snd_ok_d;
  logic                      snd_bit_q, snd_bit_d;
  logic [SequenceWidth-1:0]  acc_q, acc_d;
  logic                      dig_err_q, dig_err_d;

  logic [abfp_pkg::ByteW-1:0] b;
  logic [abfp_pkg::ByteW-1:0] diff;
  logic [3:0]                 digit;
  logic                       is_digit;
  logic [ExtW-1:0]            acc_ext;
  logic [ExtW-1:0]            acc_next;
  logic                       overflow;
  logic [abfp_pkg::SeqOutW-1:0] seq_out;
  abfp_pkg::status_e          status;

  assign b        = byte_i.frame_byte;
  assign diff     = b - abfp_pkg::CharZero;
  assign digit    = diff[3:0];
  assign is_digit = (b >= abfp_pkg::CharZero) && (b <= abfp_pkg::CharNine);
  assign acc_ext  = {4'b0000, acc_q};
  // acc * 10 + digit as shift-add; any bit above the width means overflow
  assign acc_next = (acc_ext << 3) + (acc_ext << 1) + {{(ExtW-4){1'b0}}, digit};
  assign overflow = |acc_next[ExtW-1:SequenceWidth];

  always_comb begin
    pos_d     = pos_q;
    prefix_d  = prefix_q;
    snd_ok_d  = snd_ok_q;
    snd_bit_d = snd_bit_q;
    acc_d     = acc_q;
    dig_err_d = dig_err_q;
    if (step_i) begin
      priority if (pos_q < abfp_pkg::PrefixLen) begin
        if (b != abfp_pkg::prefix_byte(pos_q[2:0])) begin
          prefix_d = 1'b0;
        end
      end else if (pos_q == abfp_pkg::SenderPos) begin
        if (b == abfp_pkg::CharZero || b == abfp_pkg::CharOne) begin
          snd_bit_d = b[0];
        end else begin
          snd_ok_d = 1'b0;
        end
      end else if (pos_q == abfp_pkg::CommaPos) begin
        if (b != abfp_pkg::CharComma) begin
          snd_ok_d = 1'b0;
        end
      end else if (!dig_err_q) begin
        if (!is_digit || overflow) begin
          dig_err_d = 1'b1;
        end else begin
          acc_d = acc_next[SequenceWidth-1:0];
        end
      end
      if (pos_q < abfp_pkg::SatPos) begin
        pos_d = pos_q + abfp_pkg::PosW'(1);
      end
    end
  end

  // Result uses the flags as updated by the final byte.
  always_comb begin
    priority if (pos_q < abfp_pkg::DigitPos || !prefix_d) begin
      status = abfp_pkg::StFormat;
    end else if (!snd_ok_d) begin
      status = abfp_pkg::StSender;
    end else if (dig_err_d) begin
      status = abfp_pkg::StSequence;
    end else begin
      status = abfp_pkg::StOk;
    end
  end

  generate
    if (SequenceWidth >= abfp_pkg::SeqOutW) begin : g_trunc
      assign seq_out = acc_d[abfp_pkg::SeqOutW-1:0];
    end else begin : g_ext
      assign seq_out = {{(abfp_pkg::SeqOutW-SequenceWidth){1'b0}}, acc_d};
    end
  endgenerate

  assign res_valid_o = step_i && byte_i.last_byte;

  always_comb begin
    res_o.status          = status;
    res_o.sender          = 1'b0;
    res_o.sequence_number = '0;
    if (status == abfp_pkg::StOk) begin
      res_o.sender          = snd_bit_d;
      res_o.sequence_number = seq_out;
    end
  end

  // Return to the idle frame state after the final byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      prefix_q  <= 1'b1;
      snd_ok_q  <= 1'b1;
      snd_bit_q <= 1'b0;
      acc_q     <= '0;
      dig_err_q <= 1'b0;
    end else if (res_valid_o) begin
      pos_q     <= '0;
      prefix_q  <= 1'b1;
      snd_ok_q  <= 1'b1;
      snd_bit_q <= 1'b0;
      acc_q     <= '0;
      dig_err_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      prefix_q  <= prefix_d;
      snd_ok_q  <= snd_ok_d;
      snd_bit_q <= snd_bit_d;
      acc_q     <= acc_d;
      dig_err_q <= dig_err_d;
    end
  end

endmodule

@@ hdl/abfp_result_reg.sv @@
// Output register holding one parse result until the transaction completes.
module abfp_result_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  abfp_pkg::result_t res_i,
  input  logic              out_ready_i,
  output logic              free_o,
  output logic              valid_o,
  output abfp_pkg::result_t res_o
);

  logic              valid_q, valid_d;
  abfp_pkg::result_t res_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

@@ hdl/ascii_beacon_frame_parser.sv @@
// Top level of the ASCII beacon frame parser.
// Path: a final byte passes the input register, then its result is registered in the result register.
// Throughput: one byte per cycle unless a final byte waits for a held result register, set
// by the input register feeding one shift-add-compare step into the state and result registers.
// Reset: asynchronous, active low; clears frame state and both valid flags.
`include "ascii_beacon_frame_parser_macros.svh"
module ascii_beacon_frame_parser #(
  parameter int unsigned SEQUENCE_WIDTH = abfp_pkg::SeqWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    frame_byte_i,
  input  logic                          last_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic                          sender_o,
  output logic [abfp_pkg::SeqOutW-1:0]  sequence_number_o
);

  abfp_pkg::byte_t   in_byte;
  abfp_pkg::byte_t   s1_byte;
  logic              s1_valid;
  logic              advance;
  logic              out_free;
  logic              res_valid;
  abfp_pkg::result_t res;
  abfp_pkg::result_t out_res;

  assign in_byte.frame_byte = frame_byte_i;
  assign in_byte.last_byte  = last_byte_i;

  // Hold a final byte until the result register can take its result.
  assign advance = s1_valid && (!s1_byte.last_byte || out_free);

  abfp_input_reg u_input_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .byte_i     (in_byte),
    .advance_i  (advance),
    .valid_o    (s1_valid),
    .byte_o     (s1_byte)
  );

  abfp_parse_core #(
    .SequenceWidth (SEQUENCE_WIDTH)
  ) u_parse_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (s1_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  abfp_result_reg u_result_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .out_ready_i (out_ready_i),
    .free_o      (out_free),
    .valid_o     (out_valid_o),
    .res_o       (out_res)
  );

  assign status_o          = out_res.status;
  assign sender_o          = out_res.sender;
  assign sequence_number_o = out_res.sequence_number;

  `ABFP_ASSERT_IMPLY(a_err_fields_zero, out_valid_o && status_o != abfp_pkg::StOk, !sender_o && sequence_number_o == '0, "error result carries nonzero fields")
  `ABFP_ASSERT_IMPLY(a_no_result_overwrite, res_valid, out_free, "result loaded into a held output register")
  `ABFP_ASSERT_NEXT(a_final_gives_result, advance && s1_byte.last_byte, out_valid_o, "final byte produced no result")
  `ABFP_ASSERT_IMPLY(a_stall_has_byte, !in_ready_o, s1_valid, "input stalled with empty input register")

endmodule
